[sv/poisson_disk_candidate_check_unit_macros.svh]
// poisson_disk_candidate_check_unit_macros.svh
// assertion macros shared by the candidate check unit; no dependencies
`ifndef POISSON_DISK_CANDIDATE_CHECK_UNIT_MACROS_SVH
`define POISSON_DISK_CANDIDATE_CHECK_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define PDC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define PDC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pdc_pkg.sv]
// pdc_pkg.sv
// shared types and constants of the candidate check unit; no dependencies
package pdc_pkg;

    localparam int unsigned CellIdxW = 16;
    localparam int unsigned CountW   = 11;
    localparam logic [CountW-1:0] CountMax = 11'd2047;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_SEED  = 2'd1,
        CMD_TEST  = 2'd2,
        CMD_TEST3 = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_RANGE    = 3'd1,
        ST_OUTSIDE  = 3'd2,
        ST_FULL     = 3'd3,
        ST_OCCUPIED = 3'd4,
        ST_CLOSE    = 3'd5,
        ST_CLEARED  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        REG_X_LOW       = 3'd0,
        REG_X_HIGH      = 3'd1,
        REG_Y_LOW       = 3'd2,
        REG_Y_HIGH      = 3'd3,
        REG_CELL_WIDTH  = 3'd4,
        REG_CELL_HEIGHT = 3'd5,
        REG_MIN_RADIUS  = 3'd6,
        REG_MAX_POINTS  = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_LOCATE, S_CLEAR, S_OWN_RD, S_OWN_CHK,
        S_NB_ISSUE, S_NB_WAIT, S_DIST, S_CMP, S_WRITE, S_OUT
    } fsm_t;

    typedef struct packed {
        logic [15:0] x_low;
        logic [15:0] x_high;
        logic [15:0] y_low;
        logic [15:0] y_high;
        logic [15:0] cell_width;
        logic [15:0] cell_height;
        logic [15:0] min_radius;
        logic [10:0] max_points;
    } cfg_t;

    // divider handshake
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

[sv/pdc_divider.sv]
// pdc_divider.sv
// restoring divider, one quotient bit a cycle, x and y in parallel; uses pdc_pkg
module pdc_divider (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [15:0]    num_x,
    input  logic [15:0]    den_x,
    input  logic [15:0]    num_y,
    input  logic [15:0]    den_y,
    output pdc_pkg::div_ctl_t ctl,
    output logic [15:0]    quot_x,
    output logic [15:0]    quot_y
);
    import pdc_pkg::*;

    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [15:0] qx_reg, qy_reg, nx_reg, ny_reg;
    logic [16:0] rx_reg, ry_reg;
    logic [16:0] rx_sh, ry_sh;

    assign rx_sh = {rx_reg[15:0], nx_reg[15]};
    assign ry_sh = {ry_reg[15:0], ny_reg[15]};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd16;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            nx_reg <= num_x;
            ny_reg <= num_y;
            rx_reg <= '0;
            ry_reg <= '0;
        end else if (busy_reg) begin
            nx_reg <= {nx_reg[14:0], 1'b0};
            ny_reg <= {ny_reg[14:0], 1'b0};
            if (rx_sh >= {1'b0, den_x}) begin
                rx_reg <= rx_sh - {1'b0, den_x};
                qx_reg <= {qx_reg[14:0], 1'b1};
            end else begin
                rx_reg <= rx_sh;
                qx_reg <= {qx_reg[14:0], 1'b0};
            end
            if (ry_sh >= {1'b0, den_y}) begin
                ry_reg <= ry_sh - {1'b0, den_y};
                qy_reg <= {qy_reg[14:0], 1'b1};
            end else begin
                ry_reg <= ry_sh;
                qy_reg <= {qy_reg[14:0], 1'b0};
            end
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quot_x    = qx_reg;
    assign quot_y    = qy_reg;

endmodule

[sv/pdc_grid_mem.sv]
// pdc_grid_mem.sv
// grid point store: one synchronous ram holding x and y per cell; uses pdc_pkg
module pdc_grid_mem #(
    parameter int unsigned CELLS = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);
    import pdc_pkg::*;

    logic [31:0] mem [CELLS];
    logic [31:0] rd_reg;

    // single write, single registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;

endmodule

[sv/poisson_disk_candidate_check_unit.sv]
// poisson_disk_candidate_check_unit.sv
// top level: config, sequencer, occupancy/epoch ram; uses pdc_pkg, pdc_divider,
// pdc_grid_mem and the assertion macro header
//
// channel  | direction | payload
// s_axis   | in        | tdata {cand_y, cand_x, command}, 34 bits in 40
// m_axis   | out       | tdata {point_count, cell_index, status}, 24 bits
// cfg      | in        | cfg_index 3 bits, cfg_data 16 bits
//
// one item at a time: a clear goes to S_OUT, via S_CLEAR when the epoch wraps;
// a test out of range goes S_DIV then S_OUT; otherwise S_DIV starts the two
// 16-step dividers, S_LOCATE waits, S_OWN_RD and S_OWN_CHK read the own cell tag,
// then a seed writes and reports. a test walks up to 25 neighbour offsets,
// S_NB_ISSUE, S_NB_WAIT and S_CMP each, plus S_DIST where the cell holds a point.
// clear costs nothing per cell: each cell carries an epoch tag compared with
// a global epoch; every sixteenth clear wraps it and sweeps the tag ram.
// after reset the tag ram is swept with s_tready low.
// the result sits in an output register; a stalled m_tready holds the block.
`include "poisson_disk_candidate_check_unit_macros.svh"
module poisson_disk_candidate_check_unit #(
    parameter int unsigned GRID_COLUMNS = 32,
    parameter int unsigned GRID_ROWS    = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // command[1:0], cand_x[17:2], cand_y[33:18]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status[2:0], cell_index[12:3], point_count[23:13]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import pdc_pkg::*;

    localparam int unsigned CELLS = GRID_COLUMNS * GRID_ROWS;
    localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int unsigned CW    = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
    localparam int unsigned RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int unsigned EW    = 4;

    // configuration registers
    cfg_t cfg_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_low       <= 16'd0;
            cfg_reg.x_high      <= 16'd65535;
            cfg_reg.y_low       <= 16'd0;
            cfg_reg.y_high      <= 16'd65535;
            cfg_reg.cell_width  <= 16'd1024;
            cfg_reg.cell_height <= 16'd1024;
            cfg_reg.min_radius  <= 16'd1448;
            cfg_reg.max_points  <= 11'd1024;
        end else if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_X_LOW:       cfg_reg.x_low       <= cfg_data;
                REG_X_HIGH:      cfg_reg.x_high      <= cfg_data;
                REG_Y_LOW:       cfg_reg.y_low       <= cfg_data;
                REG_Y_HIGH:      cfg_reg.y_high      <= cfg_data;
                REG_CELL_WIDTH:  cfg_reg.cell_width  <= cfg_data;
                REG_CELL_HEIGHT: cfg_reg.cell_height <= cfg_data;
                REG_MIN_RADIUS:  cfg_reg.min_radius  <= cfg_data;
                REG_MAX_POINTS:  cfg_reg.max_points  <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // state and item registers
    fsm_t state_reg, state_next;
    logic [1:0]  cmd_reg;
    logic [15:0] x_reg, y_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [AW-1:0] idx_reg;
    logic [CountW-1:0] count_reg, count_next;
    logic [EW-1:0] epoch_reg, epoch_next;
    logic [AW:0]   sweep_reg, sweep_next;
    logic [2:0]  dr_reg, dr_next, dc_reg, dc_next;
    logic [AW-1:0] nb_idx_reg, nb_idx_next;
    logic        nb_vld_reg, nb_vld_next;
    logic [32:0] d2_reg;
    logic [31:0] r2_reg;
    logic [15:0] dx_reg, dy_reg;
    logic        m_tvalid_reg;
    logic [2:0]  st_reg, st_next;
    logic [9:0]  oidx_reg, oidx_next;

    // divider
    div_ctl_t   dctl;
    logic       div_start;
    logic [15:0] qx, qy;
    pdc_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num_x(x_reg), .den_x(cfg_reg.cell_width),
        .num_y(y_reg), .den_y(cfg_reg.cell_height),
        .ctl(dctl), .quot_x(qx), .quot_y(qy)
    );

    // epoch tag ram: cell occupied when tag matches current epoch
    logic [EW:0]   tag_mem [CELLS];
    logic [EW:0]   tag_rd_reg;
    logic          tag_we;
    logic [AW-1:0] tag_waddr, tag_raddr;
    logic [EW:0]   tag_wdata;
    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        tag_rd_reg <= tag_mem[tag_raddr];
    end
    logic tag_hit;
    assign tag_hit = tag_rd_reg[EW] && (tag_rd_reg[EW-1:0] == epoch_reg);

    // point ram
    logic          pt_we;
    logic [AW-1:0] pt_raddr;
    logic [31:0]   pt_rd;
    pdc_grid_mem #(.CELLS(CELLS), .AW(AW)) u_mem (
        .aclk(aclk), .wr_en(pt_we), .wr_addr(idx_reg), .wr_data({y_reg, x_reg}),
        .rd_addr(pt_raddr), .rd_data(pt_rd)
    );

    // neighbour coordinates from offsets
    logic signed [RW+3:0] nr;
    logic signed [CW+3:0] nc;
    logic nb_in;
    assign nr = $signed({4'b0000, row_reg}) + $signed({{(RW+1){1'b0}}, dr_reg})
              - $signed((RW+4)'(2));
    assign nc = $signed({4'b0000, col_reg}) + $signed({{(CW+1){1'b0}}, dc_reg})
              - $signed((CW+4)'(2));
    assign nb_in = (nr >= 0) && (nr < $signed((RW+4)'(GRID_ROWS)))
                && (nc >= 0) && (nc < $signed((CW+4)'(GRID_COLUMNS)));
    logic [AW-1:0] nb_idx;
    assign nb_idx = AW'(nr[RW-1:0] * GRID_COLUMNS) + AW'(nc[CW-1:0]);

    // range and locate checks
    logic in_range, locate_ok;
    logic [31:0] cell_full;
    assign in_range = (cfg_reg.x_low < x_reg) && (x_reg < cfg_reg.x_high)
                   && (cfg_reg.y_low < y_reg) && (y_reg < cfg_reg.y_high);
    assign locate_ok = (cfg_reg.cell_width != 16'd0) && (cfg_reg.cell_height != 16'd0)
                    && ({16'd0, qx} < 32'(GRID_COLUMNS)) && ({16'd0, qy} < 32'(GRID_ROWS));
    assign cell_full = 32'(qy) * 32'(GRID_COLUMNS) + 32'(qx);

    logic [15:0] px, py;
    assign px = pt_rd[15:0];
    assign py = pt_rd[31:16];

    // sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        epoch_next   = epoch_reg;
        sweep_next   = sweep_reg;
        dr_next      = dr_reg;
        dc_next      = dc_reg;
        nb_idx_next  = nb_idx_reg;
        nb_vld_next  = nb_vld_reg;
        st_next      = st_reg;
        oidx_next    = oidx_reg;
        div_start    = 1'b0;
        tag_we       = 1'b0;
        tag_waddr    = idx_reg;
        tag_wdata    = {1'b1, epoch_reg};
        tag_raddr    = idx_reg;
        pt_we        = 1'b0;
        pt_raddr     = nb_idx_reg;
        s_tready     = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                tag_we    = 1'b1;
                tag_waddr = sweep_reg[AW-1:0];
                tag_wdata = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == (AW+1)'(CELLS - 1)) begin
                    state_next = (st_reg == ST_CLEARED) ? S_OUT : S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = !m_tvalid_reg;
                if (s_tvalid && !m_tvalid_reg) begin
                    if (cmd_t'(s_tdata[1:0]) == CMD_CLEAR) begin
                        count_next = '0;
                        st_next    = ST_CLEARED;
                        oidx_next  = '0;
                        epoch_next = epoch_reg + 1'b1;
                        sweep_next = '0;
                        state_next = (epoch_reg == {EW{1'b1}}) ? S_CLEAR : S_OUT;
                    end else begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (cmd_reg != CMD_SEED && !in_range) begin
                    st_next = ST_RANGE;
                    oidx_next = '0;
                    state_next = S_OUT;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_LOCATE;
                end
            end
            S_LOCATE: begin
                if (dctl.done) begin
                    if (!locate_ok) begin
                        st_next = ST_OUTSIDE;
                        oidx_next = '0;
                        state_next = S_OUT;
                    end else begin
                        oidx_next  = cell_full[9:0];
                        state_next = S_OWN_RD;
                    end
                end
            end
            S_OWN_RD: begin
                tag_raddr  = idx_reg;
                dr_next    = '0;
                dc_next    = '0;
                state_next = S_OWN_CHK;
            end
            S_OWN_CHK: begin
                if (cmd_reg == CMD_SEED) begin
                    if (!tag_hit && count_reg < CountMax) count_next = count_reg + 1'b1;
                    state_next = S_WRITE;
                end else if (count_reg >= cfg_reg.max_points) begin
                    st_next = ST_FULL;
                    state_next = S_OUT;
                end else if (tag_hit) begin
                    st_next = ST_OCCUPIED;
                    state_next = S_OUT;
                end else begin
                    state_next = S_NB_ISSUE;
                end
            end
            S_NB_ISSUE: begin
                // issue tag and point read for the current offset
                tag_raddr   = nb_idx;
                pt_raddr    = nb_idx;
                nb_idx_next = nb_idx;
                nb_vld_next = nb_in && (nb_idx != idx_reg);
                state_next  = S_NB_WAIT;
            end
            S_NB_WAIT: begin
                state_next = (nb_vld_reg && tag_hit) ? S_DIST : S_CMP;
                if (!(nb_vld_reg && tag_hit)) nb_vld_next = 1'b0;
            end
            S_DIST: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (nb_vld_reg && d2_reg < {1'b0, r2_reg}) begin
                    st_next = ST_CLOSE;
                    state_next = S_OUT;
                end else if (dr_reg == 3'd4 && dc_reg == 3'd4) begin
                    count_next = count_reg + 1'b1;
                    state_next = S_WRITE;
                end else begin
                    if (dc_reg == 3'd4) begin
                        dc_next = '0;
                        dr_next = dr_reg + 1'b1;
                    end else begin
                        dc_next = dc_reg + 1'b1;
                    end
                    state_next = S_NB_ISSUE;
                end
            end
            S_WRITE: begin
                tag_we = 1'b1;
                pt_we  = 1'b1;
                st_next = ST_ACCEPTED;
                state_next = S_OUT;
            end
            S_OUT: begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            count_reg    <= '0;
            epoch_reg    <= '0;
            sweep_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            st_reg       <= ST_RANGE;
            nb_vld_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            epoch_reg  <= epoch_next;
            sweep_reg  <= sweep_next;
            st_reg     <= st_next;
            nb_vld_reg <= nb_vld_next;
            if (state_reg == S_OUT) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        dr_reg      <= dr_next;
        dc_reg      <= dc_next;
        nb_idx_reg  <= nb_idx_next;
        oidx_reg    <= oidx_next;
        r2_reg      <= 32'(cfg_reg.min_radius) * 32'(cfg_reg.min_radius);
        if (s_tready && s_tvalid) begin
            cmd_reg <= s_tdata[1:0];
            x_reg   <= s_tdata[17:2];
            y_reg   <= s_tdata[33:18];
        end
        if (state_reg == S_LOCATE && dctl.done) begin
            col_reg <= qx[CW-1:0];
            row_reg <= qy[RW-1:0];
            idx_reg <= cell_full[AW-1:0];
        end
        if (state_reg == S_NB_WAIT) begin
            dx_reg <= (px > x_reg) ? px - x_reg : x_reg - px;
            dy_reg <= (py > y_reg) ? py - y_reg : y_reg - py;
        end
        // sum of two squares needs one bit above 32
        if (state_reg == S_DIST) begin
            d2_reg <= {1'b0, 32'(dx_reg) * 32'(dx_reg)}
                    + {1'b0, 32'(dy_reg) * 32'(dy_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {count_reg, oidx_reg, st_reg};

    // assertions
    `PDC_ASSERT_IMP(a_idle_no_out, aclk, aresetn, s_tready, !m_tvalid_reg,
        "input taken while result pending")
    `PDC_ASSERT_NEXT(a_clear_zero, aclk, aresetn,
        s_tready && s_tvalid && s_tdata[1:0] == CMD_CLEAR, count_reg == '0,
        "clear did not zero count")
    `PDC_ASSERT_IMP(a_write_slot, aclk, aresetn, pt_we, tag_we,
        "point written without tag")
    `PDC_ASSERT_IMP(a_out_status, aclk, aresetn, m_tvalid_reg, st_reg <= ST_CLEARED,
        "bad status code")

endmodule

[verif/poisson_disk_candidate_check_unit_tb.sv]
// poisson_disk_candidate_check_unit_tb.sv
// self-checking bench for the poisson disk candidate check unit: grid predictor,
// stream driver and monitor; depends on pdc_pkg and the unit itself
`timescale 1ns / 100ps
module poisson_disk_candidate_check_unit_tb;
    import pdc_pkg::*;

    localparam int COLS  = 32;
    localparam int ROWS  = 32;
    localparam int CELLS = COLS * ROWS;

    // last field in the lowest bits, as on s_tdata
    typedef struct packed {
        logic [15:0] cand_y;
        logic [15:0] cand_x;
        logic [1:0]  command;
    } cand_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  cell_index;
        logic [10:0] point_count;
    } verdict_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    poisson_disk_candidate_check_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor copy of the grid and registers
    logic [15:0] x_low, x_high, y_low, y_high, cell_w, cell_h, min_rad;
    logic [10:0] max_pts;
    bit          occupied [CELLS];
    logic [15:0] stored_x [CELLS];
    logic [15:0] stored_y [CELLS];
    logic [10:0] point_total;

    cand_t    pending_cands[$];
    verdict_t expected_verdicts[$];
    int       mismatches;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       hold_sender;

    // squared distance test over the 5x5 cell neighbourhood
    function automatic bit near_neighbour(logic [15:0] x, logic [15:0] y,
                                          int col, int row, int own);
        longint r2, dx, dy;
        int     idx;
        r2 = longint'(min_rad) * longint'(min_rad);
        for (int r = row - 2; r <= row + 2; r++) begin
            for (int c = col - 2; c <= col + 2; c++) begin
                if (r < 0 || r >= ROWS || c < 0 || c >= COLS) continue;
                idx = r * COLS + c;
                if (idx == own || !occupied[idx]) continue;
                dx = longint'(stored_x[idx]) - longint'(x);
                dy = longint'(stored_y[idx]) - longint'(y);
                if (dx * dx + dy * dy < r2) return 1;
            end
        end
        return 0;
    endfunction

    function automatic verdict_t judge_candidate(cand_t cand);
        verdict_t v;
        int col, row, idx;
        bit seed;
        v = '0;
        seed = (cand.command == CMD_SEED);
        if (cand.command == CMD_CLEAR) begin
            for (int i = 0; i < CELLS; i++) occupied[i] = 0;
            point_total = '0;
            v.status = ST_CLEARED;
            v.point_count = point_total;
            return v;
        end
        v.point_count = point_total;
        if (!seed && !(x_low < cand.cand_x && cand.cand_x < x_high &&
                       y_low < cand.cand_y && cand.cand_y < y_high)) begin
            v.status = ST_RANGE;
            return v;
        end
        if (cell_w == 0 || cell_h == 0 || cand.cand_x / cell_w >= COLS ||
            cand.cand_y / cell_h >= ROWS) begin
            v.status = ST_OUTSIDE;
            return v;
        end
        col = cand.cand_x / cell_w;
        row = cand.cand_y / cell_h;
        idx = row * COLS + col;
        v.cell_index = idx[9:0];
        if (seed) begin
            if (!occupied[idx] && point_total < CountMax) point_total++;
        end else begin
            if (point_total >= max_pts) begin
                v.status = ST_FULL;
                return v;
            end
            if (occupied[idx]) begin
                v.status = ST_OCCUPIED;
                return v;
            end
            if (near_neighbour(cand.cand_x, cand.cand_y, col, row, idx)) begin
                v.status = ST_CLOSE;
                return v;
            end
            point_total++;
        end
        occupied[idx] = 1;
        stored_x[idx] = cand.cand_x;
        stored_y[idx] = cand.cand_y;
        v.status = ST_ACCEPTED;
        v.point_count = point_total;
        return v;
    endfunction

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // driver: one transaction at a time from the pending queue, predicted on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else if (s_tvalid && s_tready) begin
            expected_verdicts.insert(expected_verdicts.size(),
                                     judge_candidate(pending_cands[0]));
            void'(pending_cands.pop_front());
            if (pending_cands.size() > 0 && !hold_sender &&
                $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1;
                s_tdata  <= {6'd0, pending_cands[0].cand_y,
                             pending_cands[0].cand_x, pending_cands[0].command};
            end else begin
                s_tvalid <= 0;
            end
        end else if (!s_tvalid && pending_cands.size() > 0 && !hold_sender &&
                     $urandom_range(99) >= send_idle_pct) begin
            s_tvalid <= 1;
            s_tdata  <= {6'd0, pending_cands[0].cand_y,
                         pending_cands[0].cand_x, pending_cands[0].command};
        end
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        verdict_t got, want;
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{status: m_tdata[2:0], cell_index: m_tdata[12:3],
                        point_count: m_tdata[23:13]};
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction %h", m_tdata);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected st %0d cell %0d cnt %0d,",
                                      " got st %0d cell %0d cnt %0d"},
                                     want.status, want.cell_index, want.point_count,
                                     got.status, got.cell_index, got.point_count);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [15:0] value);
        @(posedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        case (idx)
            REG_X_LOW:       x_low   = value;
            REG_X_HIGH:      x_high  = value;
            REG_Y_LOW:       y_low   = value;
            REG_Y_HIGH:      y_high  = value;
            REG_CELL_WIDTH:  cell_w  = value;
            REG_CELL_HEIGHT: cell_h  = value;
            REG_MIN_RADIUS:  min_rad = value;
            default:         max_pts = value[10:0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_cands.size() > 0 || expected_verdicts.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic add_cand(cmd_t cmd, logic [15:0] x, logic [15:0] y);
        pending_cands.insert(pending_cands.size(), '{command: cmd, cand_x: x, cand_y: y});
    endtask

    // mostly in-grid tests and seeds, some clears and noise
    task automatic add_random(int n, int span);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 2)
                add_cand(CMD_CLEAR, 16'($urandom), 16'($urandom));
            else if (pick < 12)
                add_cand(CMD_SEED, 16'($urandom_range(span)), 16'($urandom_range(span)));
            else if (pick < 20)
                add_cand(cmd_t'(2'($urandom_range(3))), 16'($urandom), 16'($urandom));
            else
                add_cand(pick < 60 ? CMD_TEST : CMD_TEST3,
                         16'($urandom_range(span)), 16'($urandom_range(span)));
        end
    endtask

    initial begin
        aresetn = 0; s_tvalid = 0; s_tdata = '0; m_tready = 0;
        cfg_valid = 0; cfg_index = REG_X_LOW; cfg_data = '0;
        mismatches = 0; hold_sender = 0;
        send_idle_pct = 19; recv_idle_pct = 77;
        x_low = 0; x_high = 16'hFFFF; y_low = 0; y_high = 16'hFFFF;
        cell_w = 1024; cell_h = 1024; min_rad = 1448; max_pts = 1024;
        point_total = '0;
        for (int i = 0; i < CELLS; i++) occupied[i] = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1;

        // directed: reset settings, field extremes, every command
        add_cand(CMD_TEST, 16'h0000, 16'h0000);
        add_cand(CMD_TEST, 16'hFFFF, 16'h0100);
        add_cand(CMD_TEST, 16'h0100, 16'hFFFF);
        add_cand(CMD_SEED, 16'h0000, 16'h0000);
        add_cand(CMD_SEED, 16'hFFFF, 16'hFFFF);
        add_cand(CMD_TEST, 16'h0010, 16'h0010);
        add_cand(CMD_TEST, 16'h0200, 16'h0200);
        add_cand(CMD_TEST, 16'h0800, 16'h0100);
        add_cand(CMD_TEST3, 16'h7FFE, 16'h7FFE);
        add_cand(CMD_TEST3, 16'h7FFF, 16'h8000);
        add_cand(CMD_SEED, 16'h0010, 16'h0010);
        add_cand(CMD_SEED, 16'h5555, 16'hAAAA);
        add_cand(CMD_TEST, 16'hAAAA, 16'h5555);
        add_cand(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
        add_cand(CMD_TEST, 16'h0800, 16'h0100);
        wait_drained();

        // cell width zero reports outside grid; small max_points fills quickly
        write_reg(REG_CELL_WIDTH, 16'd0);
        add_cand(CMD_TEST, 16'h0100, 16'h0100);
        add_cand(CMD_SEED, 16'h0100, 16'h0100);
        wait_drained();
        write_reg(REG_CELL_WIDTH, 16'd1024);
        write_reg(REG_CELL_HEIGHT, 16'd0);
        add_cand(CMD_TEST, 16'h0100, 16'h0100);
        wait_drained();
        write_reg(REG_CELL_HEIGHT, 16'd1024);
        write_reg(REG_MAX_POINTS, 16'd0);
        add_cand(CMD_TEST, 16'h0100, 16'h0100);
        add_cand(CMD_SEED, 16'h0100, 16'h0100);
        wait_drained();
        write_reg(REG_MAX_POINTS, 16'd2);
        add_cand(CMD_CLEAR, 16'd0, 16'd0);
        add_cand(CMD_TEST, 16'h0100, 16'h0100);
        add_cand(CMD_TEST, 16'h2100, 16'h2100);
        add_cand(CMD_TEST, 16'h4100, 16'h4100);
        wait_drained();

        // random phase one: reset geometry, sender 19 / receiver 77
        write_reg(REG_MAX_POINTS, 16'd1024);
        add_cand(CMD_CLEAR, 16'd0, 16'd0);
        add_random(450, 16'hFFFF);
        wait_drained();

        // let some traffic start, then pause the sender until all results are back
        add_random(20, 16'hFFFF);
        repeat (200) @(posedge aclk);
        hold_sender = 1;
        while (expected_verdicts.size() > 0 || s_tvalid) @(posedge aclk);
        repeat (20) @(posedge aclk);
        hold_sender = 0;
        wait_drained();

        // phase two: small cells, wide grid, tight ranges, swapped idling
        send_idle_pct = 77; recv_idle_pct = 19;
        write_reg(REG_X_LOW, 16'd100);
        write_reg(REG_X_HIGH, 16'd3000);
        write_reg(REG_Y_LOW, 16'd50);
        write_reg(REG_Y_HIGH, 16'd3100);
        write_reg(REG_CELL_WIDTH, 16'd64);
        write_reg(REG_CELL_HEIGHT, 16'd100);
        write_reg(REG_MIN_RADIUS, 16'd90);
        write_reg(REG_MAX_POINTS, 16'd300);
        add_cand(CMD_CLEAR, 16'd0, 16'd0);
        add_random(500, 3200);
        wait_drained();

        // phase three: extremes, no idling
        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(REG_X_LOW, 16'hFFFF);
        add_random(40, 16'hFFFF);
        wait_drained();
        write_reg(REG_X_LOW, 16'd0);
        write_reg(REG_CELL_WIDTH, 16'd1);
        write_reg(REG_CELL_HEIGHT, 16'd1);
        write_reg(REG_MIN_RADIUS, 16'hFFFF);
        write_reg(REG_MAX_POINTS, 16'd1024);
        add_random(80, 40);
        wait_drained();
        write_reg(REG_CELL_WIDTH, 16'hFFFF);
        write_reg(REG_CELL_HEIGHT, 16'hFFFF);
        write_reg(REG_MIN_RADIUS, 16'd0);
        add_random(60, 16'hFFFF);
        wait_drained();
        write_reg(REG_CELL_WIDTH, 16'd512);
        write_reg(REG_CELL_HEIGHT, 16'd512);
        write_reg(REG_MIN_RADIUS, 16'd700);
        write_reg(REG_X_HIGH, 16'hFFFF);
        write_reg(REG_Y_LOW, 16'd0);
        write_reg(REG_Y_HIGH, 16'hFFFF);
        add_cand(CMD_CLEAR, 16'd0, 16'd0);
        add_random(650, 16383);
        wait_drained();

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #800ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
